>>> hdl/periodic_date_time_session_table_unit_assert.svh
// Assertion macros for the periodic date-time session table unit.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef PERIODIC_DATE_TIME_SESSION_TABLE_UNIT_ASSERT_SVH
`define PERIODIC_DATE_TIME_SESSION_TABLE_UNIT_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define PDTST_ASSERT_IMPL(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("pdtst: assertion failed");

// Condition implies consequence in the following cycle.
`define PDTST_ASSERT_NEXT(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("pdtst: assertion failed");

`endif

>>> hdl/pdtst_pkg.sv
// Shared types, codes and helpers for the periodic date-time session table.
// No dependencies; used by every module of the block.
`default_nettype none

package pdtst_pkg;

	localparam int SESSIONS = 8;
	localparam int SLOT_W   = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
	localparam int MAX_OUT  = 8;
	localparam int CNT_W    = $clog2(MAX_OUT + 1);

	localparam logic [15:0] TPS_RESET = 16'd1000;

	// function codes
	localparam logic [2:0] FN_OPEN    = 3'd0;
	localparam logic [2:0] FN_CLOSE   = 3'd1;
	localparam logic [2:0] FN_ENQUIRY = 3'd2;
	localparam logic [2:0] FN_UNKNOWN = 3'd3;
	localparam logic [2:0] FN_POLL    = 3'd4;

	// status codes
	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_FULL       = 2'd1;
	localparam logic [1:0] STAT_NO_SESSION = 2'd2;
	localparam logic [1:0] STAT_BAD_TAG    = 2'd3;

	// result kinds
	localparam logic KIND_TIME   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef struct packed {
		logic [15:0] num;
		logic [7:0]  ivl;
		logic [7:0]  elapsed;
		logic [31:0] prev;
	} slot_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] idx;
		slot_t             ent;
	} tbl_wr_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	typedef struct packed {
		logic        kind;
		logic [1:0]  status;
		logic [15:0] session;
		logic [15:0] mjd;
		logic [5:0]  hour_bcd;
		logic [6:0]  minute_bcd;
		logic [6:0]  second_bcd;
		logic        last;
	} res_t;

	// two BCD digits of a value below 64
	function automatic logic [6:0] to_bcd(input logic [5:0] v);
		logic [2:0] t;
		logic [5:0] r;
		if (v >= 6'd60) begin
			t = 3'd6; r = v - 6'd60;
		end else if (v >= 6'd50) begin
			t = 3'd5; r = v - 6'd50;
		end else if (v >= 6'd40) begin
			t = 3'd4; r = v - 6'd40;
		end else if (v >= 6'd30) begin
			t = 3'd3; r = v - 6'd30;
		end else if (v >= 6'd20) begin
			t = 3'd2; r = v - 6'd20;
		end else if (v >= 6'd10) begin
			t = 3'd1; r = v - 6'd10;
		end else begin
			t = 3'd0; r = v;
		end
		return {t, r[3:0]};
	endfunction

	function automatic res_t mk_status(input logic [1:0] st, input logic [15:0] sess);
		res_t r;
		r            = '0;
		r.kind       = KIND_STATUS;
		r.status     = st;
		r.session    = sess;
		return r;
	endfunction

	function automatic res_t mk_reply(input logic [15:0] sess, input logic [15:0] mjd,
			input logic [4:0] hr, input logic [5:0] mn, input logic [5:0] sc);
		res_t       r;
		logic [6:0] hb;
		r            = '0;
		hb           = to_bcd({1'b0, hr});
		r.kind       = KIND_TIME;
		r.status     = STAT_OK;
		r.session    = sess;
		r.mjd        = mjd;
		r.hour_bcd   = hb[5:0];
		r.minute_bcd = to_bcd(mn);
		r.second_bcd = to_bcd(sc);
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hdl/pdtst_div.sv
// Serial restoring divider, 32-bit dividend by 16-bit divisor, one bit a cycle.
// Depends on pdtst_pkg for the status struct.
`default_nettype none

module pdtst_div (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	input  wire [31:0]               dividend,
	input  wire [15:0]               divisor,
	output pdtst_pkg::div_status_t   status,
	output logic [31:0]              quotient,
	output logic [15:0]              remainder
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] q_q;
	logic [15:0] r_q;
	logic [15:0] d_q;
	logic [16:0] trial;
	logic        fits;

	assign trial = {r_q, q_q[31]};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			q_q <= {q_q[30:0], fits};
			r_q <= fits ? 16'(trial - {1'b0, d_q}) : trial[15:0];
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = q_q;
	assign remainder   = r_q;

endmodule

`default_nettype wire

>>> hdl/pdtst_table.sv
// Session table: one slot record per session, one read and one write port.
// Depends on pdtst_pkg for slot and write-request types.
`default_nettype none

module pdtst_table (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire [pdtst_pkg::SLOT_W-1:0]       rd_idx,
	output pdtst_pkg::slot_t                  rd_ent,
	input  pdtst_pkg::tbl_wr_t                wr
);

	pdtst_pkg::slot_t slots_q [pdtst_pkg::SESSIONS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pdtst_pkg::SESSIONS; i++) begin
				slots_q[i] <= '0;
			end
		end else if (wr.en) begin
			slots_q[wr.idx] <= wr.ent;
		end
	end

	assign rd_ent = slots_q[rd_idx];

endmodule

`default_nettype wire

>>> hdl/periodic_date_time_session_table_unit.sv
// Top level of the periodic date-time session table: sequencer, config register, output register.
// Depends on pdtst_pkg, pdtst_table, pdtst_div and the assertion macro header.
//
// Use:
//   s_axis carries one command per transaction (tuser = function code). The unit takes
//   a command only when idle and then walks the session table one slot per cycle
//   unless a poll waits on the divider or on the receiver. Open, close and enquiry
//   give exactly one result. A timer poll with valid time runs the shared serial
//   divider for every scheduled slot; it yields zero to MAX_OUT replies, tlast on
//   the final one. A poll with invalid time, or one that fires nothing, yields no
//   transaction. Results leave through a single output register on m_axis. While
//   the receiver stalls, the sequencer holds at its next result; a new command may
//   still be taken once the previous one has handed over its last result.
//   apb writes ticks_per_second at address 0; it must only be written while idle.
//   Reset (arst_n low) clears every slot, sets ticks_per_second to 1000 and empties
//   the output register.
`default_nettype none
`include "periodic_date_time_session_table_unit_assert.svh"

module periodic_date_time_session_table_unit (
	input  wire         clk,
	input  wire         arst_n,
	// input stream
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [95:0] s_axis_tdata,  // session, interval, now_tick, time_valid, mjd, hour,
	                                   // minute, second, zero pad
	input  wire  [2:0]  s_axis_tuser,  // func
	// result stream
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [55:0] m_axis_tdata,  // status, reply_session, reply_mjd, hour_bcd,
	                                   // minute_bcd, second_bcd, zero pad
	output logic        m_axis_tuser,  // kind
	output logic        m_axis_tlast,
	// configuration
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int SLOT_W = pdtst_pkg::SLOT_W;
	localparam int CNT_W  = pdtst_pkg::CNT_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_UPD  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	// unpacked input fields
	logic [2:0]  in_func;
	logic [15:0] in_sess;
	logic        in_valid;
	assign in_func  = s_axis_tuser;
	assign in_sess  = s_axis_tdata[15:0];
	assign in_valid = s_axis_tdata[56];

	// configuration register
	logic [15:0] tps_q;
	logic [15:0] rate;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= pdtst_pkg::TPS_RESET;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			tps_q <= pwdata[15:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {16'd0, tps_q};
	assign rate   = (tps_q == 16'd0) ? 16'd1 : tps_q;

	// held command
	logic [2:0]  func_q;
	logic [15:0] sess_q;
	logic [7:0]  ivl_q;
	logic [31:0] now_q;
	logic        valid_q;
	logic [15:0] mjd_q;
	logic [4:0]  hr_q;
	logic [5:0]  mn_q;
	logic [5:0]  sc_q;

	// sequencer
	logic [2:0]        state_q, state_d;
	logic [SLOT_W-1:0] slot_q, slot_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	pdtst_pkg::res_t   pend_q, pend_d;
	logic              pend_v_q, pend_v_d;
	pdtst_pkg::res_t   out_q, out_d;
	logic              out_valid_q;
	logic              out_load;
	logic              out_free;
	logic              item_load;

	pdtst_pkg::slot_t      ent;
	pdtst_pkg::tbl_wr_t    tbl_wr;
	logic                  div_start;
	pdtst_pkg::div_status_t div_st;
	logic [31:0]           quo;
	logic [15:0]           rem;

	logic        last_slot;
	logic        is_match;
	logic [7:0]  e_sum;
	logic        hit;
	logic [7:0]  e_new;

	pdtst_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (slot_q),
		.rd_ent (ent),
		.wr     (tbl_wr)
	);

	pdtst_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (now_q - ent.prev),
		.divisor   (rate),
		.status    (div_st),
		.quotient  (quo),
		.remainder (rem)
	);

	assign out_free  = !out_valid_q || m_axis_tready;
	assign last_slot = (slot_q == SLOT_W'(pdtst_pkg::SESSIONS - 1));
	assign is_match  = (ent.num == sess_q);
	assign e_sum     = ent.elapsed + quo[7:0];
	assign hit       = (e_sum >= ent.ivl);
	assign e_new     = hit ? (e_sum - ent.ivl) : e_sum;

	assign s_axis_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d   = state_q;
		slot_d    = slot_q;
		cnt_d     = cnt_q;
		pend_d    = pend_q;
		pend_v_d  = pend_v_q;
		out_load  = 1'b0;
		out_d     = pend_q;
		item_load = 1'b0;
		div_start = 1'b0;
		tbl_wr    = '0;
		tbl_wr.idx = slot_q;

		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					item_load = 1'b1;
					slot_d    = '0;
					cnt_d     = '0;
					case (in_func)
						pdtst_pkg::FN_OPEN, pdtst_pkg::FN_CLOSE, pdtst_pkg::FN_ENQUIRY: begin
							if (in_sess == 16'd0) begin
								pend_d   = pdtst_pkg::mk_status(pdtst_pkg::STAT_NO_SESSION, 16'd0);
								pend_v_d = 1'b1;
								state_d  = ST_FIN;
							end else begin
								state_d = ST_SCAN;
							end
						end
						pdtst_pkg::FN_POLL: begin
							if (in_valid) begin
								state_d = ST_SCAN;
							end
						end
						default: begin
							pend_d   = pdtst_pkg::mk_status(pdtst_pkg::STAT_BAD_TAG, in_sess);
							pend_v_d = 1'b1;
							state_d  = ST_FIN;
						end
					endcase
				end
			end

			ST_SCAN: begin
				case (func_q)
					pdtst_pkg::FN_OPEN: begin
						if (ent.num == 16'd0) begin
							tbl_wr.en      = 1'b1;
							tbl_wr.ent     = '0;
							tbl_wr.ent.num = sess_q;
							pend_d   = pdtst_pkg::mk_status(pdtst_pkg::STAT_OK, sess_q);
							pend_v_d = 1'b1;
							state_d  = ST_FIN;
						end else if (last_slot) begin
							pend_d   = pdtst_pkg::mk_status(pdtst_pkg::STAT_FULL, sess_q);
							pend_v_d = 1'b1;
							state_d  = ST_FIN;
						end else begin
							slot_d = slot_q + SLOT_W'(1);
						end
					end
					pdtst_pkg::FN_CLOSE: begin
						if (is_match) begin
							tbl_wr.en  = 1'b1;
							tbl_wr.ent = '0;
							pend_d   = pdtst_pkg::mk_status(pdtst_pkg::STAT_OK, sess_q);
							pend_v_d = 1'b1;
							state_d  = ST_FIN;
						end else if (last_slot) begin
							pend_d   = pdtst_pkg::mk_status(pdtst_pkg::STAT_NO_SESSION, sess_q);
							pend_v_d = 1'b1;
							state_d  = ST_FIN;
						end else begin
							slot_d = slot_q + SLOT_W'(1);
						end
					end
					pdtst_pkg::FN_ENQUIRY: begin
						if (is_match) begin
							// restart the schedule; interval 0 leaves it stopped
							tbl_wr.en          = 1'b1;
							tbl_wr.ent.num     = ent.num;
							tbl_wr.ent.ivl     = ivl_q;
							tbl_wr.ent.elapsed = 8'd0;
							tbl_wr.ent.prev    = (ivl_q != 8'd0) ? now_q : 32'd0;
							if (valid_q) begin
								pend_d = pdtst_pkg::mk_reply(sess_q, mjd_q, hr_q, mn_q, sc_q);
							end else begin
								pend_d = pdtst_pkg::mk_reply(sess_q, 16'd0, 5'd0, 6'd0, 6'd0);
							end
							pend_v_d = 1'b1;
							state_d  = ST_FIN;
						end else if (last_slot) begin
							pend_d   = pdtst_pkg::mk_status(pdtst_pkg::STAT_NO_SESSION, sess_q);
							pend_v_d = 1'b1;
							state_d  = ST_FIN;
						end else begin
							slot_d = slot_q + SLOT_W'(1);
						end
					end
					pdtst_pkg::FN_POLL: begin
						if (ent.num != 16'd0 && ent.ivl != 8'd0) begin
							div_start = 1'b1;
							state_d   = ST_DIV;
						end else if (last_slot) begin
							state_d = ST_FIN;
						end else begin
							slot_d = slot_q + SLOT_W'(1);
						end
					end
					default: begin
						state_d = ST_FIN;
					end
				endcase
			end

			ST_DIV: begin
				if (div_st.done) begin
					state_d = ST_UPD;
				end
			end

			ST_UPD: begin
				if (quo == 32'd0) begin
					state_d = last_slot ? ST_FIN : ST_SCAN;
					slot_d  = last_slot ? slot_q : slot_q + SLOT_W'(1);
				end else if (!(hit && pend_v_q && !out_free)) begin
					// prev advances by whole seconds: now minus the leftover ticks
					tbl_wr.en          = 1'b1;
					tbl_wr.ent.num     = ent.num;
					tbl_wr.ent.ivl     = ent.ivl;
					tbl_wr.ent.elapsed = e_new;
					tbl_wr.ent.prev    = now_q - {16'd0, rem};
					if (hit) begin
						if (pend_v_q) begin
							out_load   = 1'b1;
							out_d      = pend_q;
							out_d.last = 1'b0;
						end
						pend_d   = pdtst_pkg::mk_reply(ent.num, mjd_q, hr_q, mn_q, sc_q);
						pend_v_d = 1'b1;
						cnt_d    = cnt_q + CNT_W'(1);
					end
					if (last_slot || (hit && (cnt_q + CNT_W'(1) == CNT_W'(pdtst_pkg::MAX_OUT))))
					begin
						state_d = ST_FIN;
					end else begin
						state_d = ST_SCAN;
						slot_d  = slot_q + SLOT_W'(1);
					end
				end
			end

			ST_FIN: begin
				if (!pend_v_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					out_load   = 1'b1;
					out_d      = pend_q;
					out_d.last = 1'b1;
					pend_v_d   = 1'b0;
					state_d    = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_q      <= '0;
			cnt_q       <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			slot_q   <= slot_d;
			cnt_q    <= cnt_d;
			pend_v_q <= pend_v_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_q <= pend_d;
		if (out_load) begin
			out_q <= out_d;
		end
		if (item_load) begin
			func_q  <= in_func;
			sess_q  <= in_sess;
			ivl_q   <= s_axis_tdata[23:16];
			now_q   <= s_axis_tdata[55:24];
			valid_q <= in_valid;
			mjd_q   <= s_axis_tdata[72:57];
			hr_q    <= s_axis_tdata[77:73];
			mn_q    <= s_axis_tdata[83:78];
			sc_q    <= s_axis_tdata[89:84];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tlast  = out_q.last;
	assign m_axis_tdata  = {2'b00, out_q.second_bcd, out_q.minute_bcd, out_q.hour_bcd,
	                        out_q.mjd, out_q.session, out_q.status};

	// the divider only runs while the sequencer waits on it
	`PDTST_ASSERT_IMPL(a_div_owned, div_st.busy, state_q == ST_DIV)
	// a result never overwrites one the receiver has not taken
	`PDTST_ASSERT_IMPL(a_out_no_overrun, out_load, !out_valid_q || m_axis_tready)
	// a poll never goes beyond its reply limit
	`PDTST_ASSERT_IMPL(a_cnt_limit, state_q != ST_IDLE, cnt_q <= CNT_W'(pdtst_pkg::MAX_OUT))
	// a held result is always flushed before the next command is taken
	`PDTST_ASSERT_NEXT(a_fin_flush, state_q == ST_FIN && out_free, !pend_v_q)

endmodule

`default_nettype wire
